[hw/rtl/i2crtm_pkg.sv]
// Types, codes and constants shared by the I2C register transaction master.
package i2crtm_pkg;

   localparam int MAX_BYTES = 8;
   localparam int CNT_W     = 4;
   localparam int IDX_W     = 3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_EVENT = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ERROR = 3'd1,
      PH_ADDR  = 3'd2,
      PH_REG   = 3'd3,
      PH_DATA  = 3'd4,
      PH_RECV  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_ADDRW = 3'd1,
      ACT_ADDRR = 3'd2,
      ACT_BYTE  = 3'd3,
      ACT_STOP  = 3'd4,
      ACT_FLUSH = 3'd5,
      ACT_ACKRX = 3'd6,
      ACT_NACKS = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ERR_UNEXPECTED = 2'd0,
      ERR_ARB_LOST   = 2'd1,
      ERR_BUS_FAULT  = 2'd2,
      ERR_NO_ACK     = 2'd3
   } error_type;

   typedef struct packed {
      logic        cmd;
      logic [6:0]  dev_addr;
      logic [7:0]  reg_addr;
      logic [3:0]  byte_count;
      logic        is_write;
      logic [63:0] write_bytes;
      logic        arb_lost;
      logic        bus_fault;
      logic        nack_seen;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      action_type  action;
      logic [7:0]  tx_byte;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic [2:0]  read_index;
      logic        busy_res;
      logic        error_flag;
      logic [1:0]  error_code;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic              write_mode;
      logic [6:0]        target_addr;
      logic [7:0]        target_reg;
      logic [CNT_W-1:0]  byte_index;
      logic [CNT_W-1:0]  byte_total;
      logic [63:0]       tx_data;
      error_type         last_error;
   } state_type;

endpackage

[hw/rtl/i2crtm_if.sv]
// Valid/ready channel interfaces for transaction requests and bus responses.
interface i2crtm_req_if;
   import i2crtm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2crtm_rsp_if;
   import i2crtm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/i2c_register_transaction_master_core.sv]
// I2C register transaction master: top level with state and response registers.
//
// Usage:
//   req_ch carries one request per transfer: a start (cmd 0) with device
//   address, register, length and write bytes, or a bus event (cmd 1) with
//   arbitration loss, bus fault, missing acknowledge and a received byte.
//   rsp_ch returns exactly one response per request: the next bus command,
//   the byte to send, any received byte with its index, and busy/error status.
//   A start is taken only while idle or in error; otherwise it is answered
//   with accepted 0 and no command.
// Response: registered, it appears in the cycle after its request transfer.
// Throughput: one request per cycle unless rsp_ch stalls; the state update and
//   command choice fit in one logic pass between state and response registers.
// Reset: the transaction state returns to idle and the response register
//   empties.
// Stall: while rsp_ch is stalled with a response pending, req_ch is not
//   ready; a new request is taken in the same cycle the pending response
//   transfers.
module i2c_register_transaction_master_core (
   input logic           clock,
   input logic           reset,
   i2crtm_req_if.sink    req_ch,
   i2crtm_rsp_if.source  rsp_ch
);
   import i2crtm_pkg::*;

   state_type state_ff, state_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   i2crtm_step u_step (
      .cur (state_ff),
      .req (req_ch.payload),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
            rsp_ff   <= rsp_in;
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

`ifndef ASSERT_OFF
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("request transfer without response");

   a_start_to_addr: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.payload.cmd == CMD_START &&
      (state_ff.phase == PH_IDLE || state_ff.phase == PH_ERROR)
      |=> state_ff.phase == PH_ADDR && rsp_ff.accepted)
      else $error("accepted start did not enter address phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_total <= CNT_W'(MAX_BYTES) &&
      state_ff.byte_index <= CNT_W'(MAX_BYTES))
      else $error("byte count out of range");

   a_error_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.error_flag && rsp_ff.busy_res))
      else $error("error and busy both set");

   a_read_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_valid
      |-> rsp_ff.action == ACT_ACKRX || rsp_ff.action == ACT_NACKS)
      else $error("received byte without receive command");
`endif

endmodule

[hw/rtl/i2crtm_step.sv]
// Next-state and response logic for one request against the current state.
module i2crtm_step (
   input  i2crtm_pkg::state_type cur,
   input  i2crtm_pkg::req_type   req,
   output i2crtm_pkg::state_type nxt,
   output i2crtm_pkg::rsp_type   rsp
);
   import i2crtm_pkg::*;

   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] rx_idx;
   logic [7:0]       next_byte;
   logic             more_tx;

   assign idx_inc   = cur.byte_index + CNT_W'(1);
   assign next_byte = cur.tx_data[{cur.byte_index[IDX_W-1:0], 3'b000} +: 8];
   assign more_tx   = (cur.byte_index < cur.byte_total) &&
                      (cur.byte_index < CNT_W'(MAX_BYTES));
   assign rx_idx    = (cur.byte_index < CNT_W'(15)) ? idx_inc : cur.byte_index;

   always_comb begin
      nxt            = cur;
      rsp            = '0;
      rsp.action     = ACT_NONE;
      if (req.cmd == CMD_START) begin
         if (cur.phase == PH_IDLE || cur.phase == PH_ERROR) begin
            rsp.accepted    = 1'b1;
            nxt.target_addr = req.dev_addr;
            nxt.target_reg  = req.reg_addr;
            nxt.byte_total  = (req.byte_count > CNT_W'(MAX_BYTES)) ?
                              CNT_W'(MAX_BYTES) : req.byte_count;
            nxt.write_mode  = req.is_write;
            nxt.tx_data     = req.write_bytes;
            nxt.byte_index  = '0;
            nxt.phase       = PH_ADDR;
            rsp.action      = ACT_ADDRW;
            rsp.tx_byte     = {req.dev_addr, 1'b0};
         end
      end else if (req.arb_lost) begin
         nxt.phase      = PH_ERROR;
         nxt.last_error = ERR_ARB_LOST;
         rsp.action     = ACT_FLUSH;
      end else if (req.bus_fault) begin
         nxt.phase      = PH_ERROR;
         nxt.last_error = ERR_BUS_FAULT;
         rsp.action     = ACT_FLUSH;
      end else begin
         case (cur.phase)
            PH_ADDR, PH_REG, PH_DATA: begin
               if (req.nack_seen) begin
                  nxt.phase      = PH_ERROR;
                  nxt.last_error = ERR_NO_ACK;
                  rsp.action     = ACT_FLUSH;
               end else if (cur.phase == PH_ADDR) begin
                  rsp.tx_byte = cur.target_reg;
                  nxt.phase   = PH_REG;
                  rsp.action  = ACT_BYTE;
               end else if (cur.phase == PH_REG && !cur.write_mode) begin
                  rsp.tx_byte = {cur.target_addr, 1'b1};
                  nxt.phase   = PH_RECV;
                  rsp.action  = ACT_ADDRR;
               end else if (more_tx) begin
                  rsp.tx_byte    = next_byte;
                  nxt.byte_index = idx_inc;
                  nxt.phase      = PH_DATA;
                  rsp.action     = ACT_BYTE;
               end else begin
                  nxt.phase  = PH_IDLE;
                  rsp.action = ACT_STOP;
               end
            end
            PH_RECV: begin
               if (cur.byte_index < cur.byte_total) begin
                  rsp.read_valid = 1'b1;
                  rsp.read_byte  = req.rx_byte;
                  rsp.read_index = cur.byte_index[IDX_W-1:0];
               end
               nxt.byte_index = rx_idx;
               if (rx_idx >= cur.byte_total) begin
                  nxt.phase  = PH_IDLE;
                  rsp.action = ACT_NACKS;
               end else begin
                  rsp.action = ACT_ACKRX;
               end
            end
            default: begin
               nxt.phase      = PH_ERROR;
               nxt.last_error = ERR_UNEXPECTED;
               rsp.action     = ACT_FLUSH;
            end
         endcase
      end
      rsp.busy_res   = (nxt.phase != PH_IDLE) && (nxt.phase != PH_ERROR);
      rsp.error_flag = (nxt.phase == PH_ERROR);
      rsp.error_code = (nxt.phase == PH_ERROR) ? nxt.last_error : ERR_UNEXPECTED;
   end

endmodule

[tb/sv/tb_top.sv]
// Testbench for the I2C register transaction master: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;
   import i2crtm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2crtm_req_if req_ch ();
   i2crtm_rsp_if rsp_ch ();

   i2c_register_transaction_master_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   state_type   bus_state;
   rsp_type     expected_rsp[$];
   rsp_type     want_rsp;
   int unsigned mismatches = 0;
   int unsigned sent_items = 0;
   int unsigned hold_cycles = 0;
   bit          tx_idle_en = 1'b1;
   bit          rx_idle_en = 1'b1;

   function automatic action_type enter_error(input error_type code);
      bus_state.phase      = PH_ERROR;
      bus_state.last_error = code;
      return ACT_FLUSH;
   endfunction

   function automatic action_type send_next_byte(output logic [7:0] tx);
      tx = 8'h00;
      if (bus_state.byte_index < bus_state.byte_total && bus_state.byte_index < MAX_BYTES) begin
         tx = bus_state.tx_data[8*bus_state.byte_index +: 8];
         bus_state.byte_index++;
         bus_state.phase = PH_DATA;
         return ACT_BYTE;
      end
      bus_state.phase = PH_IDLE;
      return ACT_STOP;
   endfunction

   function automatic rsp_type advance_bus(input req_type r);
      rsp_type o;
      o = '0;
      if (r.cmd == CMD_START) begin
         if (bus_state.phase == PH_IDLE || bus_state.phase == PH_ERROR) begin
            o.accepted            = 1'b1;
            bus_state.target_addr = r.dev_addr;
            bus_state.target_reg  = r.reg_addr;
            bus_state.byte_total  = (r.byte_count > CNT_W'(MAX_BYTES)) ?
                                    CNT_W'(MAX_BYTES) : r.byte_count;
            bus_state.write_mode  = r.is_write;
            bus_state.tx_data     = r.write_bytes;
            bus_state.byte_index  = '0;
            bus_state.phase       = PH_ADDR;
            o.action              = ACT_ADDRW;
            o.tx_byte             = {r.dev_addr, 1'b0};
         end
      end else if (r.arb_lost) begin
         o.action = enter_error(ERR_ARB_LOST);
      end else if (r.bus_fault) begin
         o.action = enter_error(ERR_BUS_FAULT);
      end else begin
         case (bus_state.phase)
            PH_ADDR: begin
               if (r.nack_seen) begin
                  o.action = enter_error(ERR_NO_ACK);
               end else begin
                  o.tx_byte       = bus_state.target_reg;
                  bus_state.phase = PH_REG;
                  o.action        = ACT_BYTE;
               end
            end
            PH_REG: begin
               if (r.nack_seen) begin
                  o.action = enter_error(ERR_NO_ACK);
               end else if (bus_state.write_mode) begin
                  o.action = send_next_byte(o.tx_byte);
               end else begin
                  o.tx_byte       = {bus_state.target_addr, 1'b1};
                  bus_state.phase = PH_RECV;
                  o.action        = ACT_ADDRR;
               end
            end
            PH_DATA: begin
               if (r.nack_seen) o.action = enter_error(ERR_NO_ACK);
               else o.action = send_next_byte(o.tx_byte);
            end
            PH_RECV: begin
               if (bus_state.byte_index < bus_state.byte_total) begin
                  o.read_valid = 1'b1;
                  o.read_byte  = r.rx_byte;
                  o.read_index = bus_state.byte_index[2:0];
               end
               if (bus_state.byte_index < 15) bus_state.byte_index++;
               if (bus_state.byte_index >= bus_state.byte_total) begin
                  bus_state.phase = PH_IDLE;
                  o.action        = ACT_NACKS;
               end else begin
                  o.action = ACT_ACKRX;
               end
            end
            default: o.action = enter_error(ERR_UNEXPECTED);
         endcase
      end
      o.busy_res   = !(bus_state.phase == PH_IDLE || bus_state.phase == PH_ERROR);
      o.error_flag = (bus_state.phase == PH_ERROR);
      o.error_code = o.error_flag ? bus_state.last_error : ERR_UNEXPECTED;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) expected_rsp.push_back(advance_bus(req_ch.payload));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with no response expected");
               mismatches++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               check_field("accepted", want_rsp.accepted, rsp_ch.payload.accepted);
               check_field("action", want_rsp.action, rsp_ch.payload.action);
               check_field("tx_byte", want_rsp.tx_byte, rsp_ch.payload.tx_byte);
               check_field("read_valid", want_rsp.read_valid, rsp_ch.payload.read_valid);
               check_field("read_byte", want_rsp.read_byte, rsp_ch.payload.read_byte);
               check_field("read_index", want_rsp.read_index, rsp_ch.payload.read_index);
               check_field("busy_res", want_rsp.busy_res, rsp_ch.payload.busy_res);
               check_field("error_flag", want_rsp.error_flag, rsp_ch.payload.error_flag);
               check_field("error_code", want_rsp.error_code, rsp_ch.payload.error_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= (hold_cycles == 0) && !(rx_idle_en && $urandom_range(0, 99) < 14);
   end

   function automatic req_type start_req(input logic [6:0] dev, input logic [7:0] regad,
                                         input logic [3:0] cnt, input logic wr,
                                         input logic [63:0] wdata);
      req_type r;
      r.cmd         = CMD_START;
      r.dev_addr    = dev;
      r.reg_addr    = regad;
      r.byte_count  = cnt;
      r.is_write    = wr;
      r.write_bytes = wdata;
      r.arb_lost    = 1'($urandom_range(0, 1));
      r.bus_fault   = 1'($urandom_range(0, 1));
      r.nack_seen   = 1'($urandom_range(0, 1));
      r.rx_byte     = 8'($urandom);
      return r;
   endfunction

   function automatic req_type event_req(input logic arb, input logic fault,
                                         input logic nack, input logic [7:0] rx);
      req_type r;
      r.cmd         = CMD_EVENT;
      r.dev_addr    = 7'($urandom);
      r.reg_addr    = 8'($urandom);
      r.byte_count  = 4'($urandom);
      r.is_write    = 1'($urandom_range(0, 1));
      r.write_bytes = {$urandom, $urandom};
      r.arb_lost    = arb;
      r.bus_fault   = fault;
      r.nack_seen   = nack;
      r.rx_byte     = rx;
      return r;
   endfunction

   function automatic req_type random_start();
      return start_req(7'($urandom), 8'($urandom), 4'($urandom), 1'($urandom_range(0, 1)),
                       {$urandom, $urandom});
   endfunction

   task automatic send_item(input req_type item);
      while (tx_idle_en && $urandom_range(0, 99) < 14) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_acks(input int unsigned count);
      repeat (count) send_item(event_req(1'b0, 1'b0, 1'b0, 8'($urandom)));
   endtask

   // One well-formed transaction with random content, optionally broken at a random step.
   task automatic run_transaction(input bit with_fault);
      logic [3:0]  cnt;
      logic        wr;
      int unsigned n;
      int unsigned steps;
      int unsigned fault_at;
      int unsigned kind;
      cnt      = 4'($urandom_range(0, 15));
      wr       = 1'($urandom_range(0, 1));
      n        = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
      steps    = 2 + (wr ? n : ((n == 0) ? 1 : n));
      fault_at = with_fault ? $urandom_range(0, steps - 1) : steps;
      send_item(start_req(7'($urandom), 8'($urandom), cnt, wr, {$urandom, $urandom}));
      for (int i = 0; i < steps; i++) begin
         if (i == fault_at) begin
            kind = $urandom_range(0, 3);
            if (kind == 3) begin
               send_item(random_start());
            end else begin
               send_item(event_req(kind == 0,
                                   kind == 1 || (kind == 0 && $urandom_range(0, 1) != 0),
                                   kind == 2 || $urandom_range(0, 1) != 0, 8'($urandom)));
               return;
            end
         end
         send_item(event_req(1'b0, 1'b0,
                             (!wr && i >= 2) ? 1'($urandom_range(0, 1)) : 1'b0,
                             8'($urandom)));
      end
   endtask

   task automatic test_directed();
      send_item(event_req(1'b0, 1'b0, 1'b0, 8'h00));
      send_item(start_req(7'h7F, 8'hFF, 4'd12, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(start_req(7'h00, 8'h00, 4'd1, 1'b0, 64'h0));
      repeat (10) send_item(event_req(1'b0, 1'b0, 1'b0, 8'hFF));
      send_item(start_req(7'h7F, 8'h00, 4'd2, 1'b0, 64'h0));
      send_acks(2);
      send_item(event_req(1'b0, 1'b0, 1'b1, 8'hA5));
      send_item(event_req(1'b0, 1'b0, 1'b0, 8'h5A));
      send_item(start_req(7'h00, 8'h00, 4'd0, 1'b0, 64'h0));
      send_acks(2);
      send_item(event_req(1'b0, 1'b0, 1'b1, 8'hFF));
      send_item(start_req(7'h55, 8'hAA, 4'd0, 1'b1, 64'h0123_4567_89AB_CDEF));
      send_acks(2);
      send_item(start_req(7'h2A, 8'h55, 4'd3, 1'b0, 64'hFEDC_BA98_7654_3210));
      send_item(event_req(1'b0, 1'b0, 1'b1, 8'h00));
      send_item(event_req(1'b1, 1'b1, 1'b1, 8'h5A));
      send_item(start_req(7'h01, 8'h80, 4'd1, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5));
      send_acks(1);
      send_item(event_req(1'b0, 1'b0, 1'b1, 8'h00));
      send_item(event_req(1'b0, 1'b1, 1'b0, 8'h00));
   endtask

   task automatic test_backpressure();
      hold_cycles <= 80;
      repeat (4) run_transaction(1'b0);
   endtask

   task automatic test_steady_flow();
      tx_idle_en = 1'b0;
      rx_idle_en <= 1'b0;
      repeat (8) run_transaction($urandom_range(0, 3) == 0);
      tx_idle_en = 1'b1;
      rx_idle_en <= 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned first;
      int unsigned pick;
      first = sent_items;
      while (sent_items - first < 320) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            if ($urandom_range(0, 1))
               send_item(random_start());
            else
               send_item(event_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 8'($urandom)));
         end else begin
            run_transaction(pick < 25);
         end
      end
   endtask

   initial begin
      bus_state      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_steady_flow();
      test_random_traffic();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
